// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;

  // Field widths
  localparam int MW   = 16;   // matrix entry
  localparam int QW   = 16;   // quaternion part
  localparam int UW   = 18;   // unscaled quaternion part, signed
  localparam int MAGW = 17;   // magnitude of an unscaled part
  localparam int SQW  = 2 * MAGW;
  localparam int SW   = 62;   // normalized sum of squares
  localparam int RW   = 31;   // square root of the normalized sum
  localparam int QTW  = 17;   // quotient bits
  localparam int NW   = RW + FRAC_BITS + 1;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [UW-1:0] u0;
    logic signed [UW-1:0] u1;
    logic signed [UW-1:0] u2;
    logic signed [UW-1:0] u3;
    branch_t              br;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQR,
    B_SUM,
    B_NORM,
    B_SQRT,
    B_DINIT,
    B_DIV,
    B_DONE
  } bstate_t;

endpackage

// ===== rtl/rmq_front.sv =====
module rmq_front (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [9*rmq_pkg::MW-1:0]     in_tdata,
  output logic                         push,
  output rmq_pkg::item_t               push_item,
  input  logic                         q_full
);

  logic signed [rmq_pkg::UW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [rmq_pkg::UW-1:0] t, d;

  // Sign extend the nine entries
  assign a00 = rmq_pkg::UW'($signed(in_tdata[15:0]));
  assign a01 = rmq_pkg::UW'($signed(in_tdata[31:16]));
  assign a02 = rmq_pkg::UW'($signed(in_tdata[47:32]));
  assign a10 = rmq_pkg::UW'($signed(in_tdata[63:48]));
  assign a11 = rmq_pkg::UW'($signed(in_tdata[79:64]));
  assign a12 = rmq_pkg::UW'($signed(in_tdata[95:80]));
  assign a20 = rmq_pkg::UW'($signed(in_tdata[111:96]));
  assign a21 = rmq_pkg::UW'($signed(in_tdata[127:112]));
  assign a22 = rmq_pkg::UW'($signed(in_tdata[143:128]));

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // Pick the branch and form the unscaled quaternion
  always_comb begin
    t = rmq_pkg::UW'(rmq_pkg::ONE) + a00 + a11 + a22;
    d = '0;
    push_item = '0;
    if (t > 0) begin
      push_item.br = rmq_pkg::BR_TRACE;
      push_item.u0 = a21 - a12;
      push_item.u1 = a02 - a20;
      push_item.u2 = a10 - a01;
      push_item.u3 = t;
    end else if (a00 > a11 && a00 > a22) begin
      d = rmq_pkg::UW'(rmq_pkg::ONE) + a00 - a11 - a22;
      push_item.br = rmq_pkg::BR_X;
      push_item.u0 = (d > 0) ? d : '0;
      push_item.u1 = a01 + a10;
      push_item.u2 = a02 + a20;
      push_item.u3 = a21 - a12;
    end else if (a11 > a22) begin
      d = rmq_pkg::UW'(rmq_pkg::ONE) + a11 - a00 - a22;
      push_item.br = rmq_pkg::BR_Y;
      push_item.u0 = a01 + a10;
      push_item.u1 = (d > 0) ? d : '0;
      push_item.u2 = a12 + a21;
      push_item.u3 = a02 - a20;
    end else begin
      d = rmq_pkg::UW'(rmq_pkg::ONE) + a22 - a00 - a11;
      push_item.br = rmq_pkg::BR_Z;
      push_item.u0 = a02 + a20;
      push_item.u1 = a12 + a21;
      push_item.u2 = (d > 0) ? d : '0;
      push_item.u3 = a10 - a01;
    end
  end

endmodule

// ===== rtl/rmq_fifo.sv =====
module rmq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rmq_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rmq_pkg::item_t pop_item
);

  rmq_pkg::item_t mem_r [rmq_pkg::QDEPTH];
  logic           wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'(rmq_pkg::QDEPTH));
  assign valid    = (cnt_r != 2'd0);
  assign pop_item = mem_r[rptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/rmq_back.sv =====
module rmq_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  rmq_pkg::item_t          q_item,
  output logic                    pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [4*rmq_pkg::QW-1:0] out_tdata,
  output logic [1:0]              out_tuser
);

  rmq_pkg::bstate_t state_r, state_nxt;

  logic [rmq_pkg::MAGW-1:0] mag_r [4];
  logic [3:0]               neg_r;
  logic [rmq_pkg::SQW-1:0]  sq_r [4];
  logic [rmq_pkg::SW-1:0]   s_r;
  logic [4:0]               k_r;
  logic [4:0]               cnt_r;
  logic [rmq_pkg::RW-1:0]   root_r;
  logic [rmq_pkg::RW+1:0]   srem_r;
  logic [rmq_pkg::NW-1:0]   n_r [4];
  logic [rmq_pkg::RW:0]     drem_r [4];
  logic [rmq_pkg::QTW-1:0]  q_r [4];
  logic                     zero_r;
  logic [1:0]               br_r;
  logic                     out_valid_r;
  logic [4*rmq_pkg::QW-1:0] out_data_r;
  logic [1:0]               out_user_r;

  logic                     load_out;
  logic                     sum_zero;
  logic [rmq_pkg::SQW+1:0]  sum_w;
  logic [rmq_pkg::RW+3:0]   sq_sh, sq_trial;
  logic                     norm_done;
  logic signed [rmq_pkg::UW-1:0] u_in [4];

  assign u_in[0] = q_item.u0;
  assign u_in[1] = q_item.u1;
  assign u_in[2] = q_item.u2;
  assign u_in[3] = q_item.u3;

  assign sum_w = (rmq_pkg::SQW+2)'(sq_r[0]) + (rmq_pkg::SQW+2)'(sq_r[1])
               + (rmq_pkg::SQW+2)'(sq_r[2]) + (rmq_pkg::SQW+2)'(sq_r[3]);
  assign sum_zero  = (sum_w == '0);
  assign norm_done = s_r[61] || s_r[60];
  assign sq_sh     = {srem_r, s_r[61:60]};
  assign sq_trial  = {2'b00, root_r, 2'b01};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmq_pkg::B_IDLE:  if (q_valid) state_nxt = rmq_pkg::B_SQR;
      rmq_pkg::B_SQR:   state_nxt = rmq_pkg::B_SUM;
      rmq_pkg::B_SUM:   state_nxt = sum_zero ? rmq_pkg::B_DONE : rmq_pkg::B_NORM;
      rmq_pkg::B_NORM:  if (norm_done) state_nxt = rmq_pkg::B_SQRT;
      rmq_pkg::B_SQRT:  if (cnt_r == 5'd0) state_nxt = rmq_pkg::B_DINIT;
      rmq_pkg::B_DINIT: state_nxt = rmq_pkg::B_DIV;
      rmq_pkg::B_DIV:   if (cnt_r == 5'd0) state_nxt = rmq_pkg::B_DONE;
      rmq_pkg::B_DONE:  if (load_out) state_nxt = rmq_pkg::B_IDLE;
      default:          state_nxt = rmq_pkg::B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      rmq_pkg::B_IDLE: pop = q_valid;
      rmq_pkg::B_DONE: load_out = !out_valid_r || out_tready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmq_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    logic [47:0]              magsh;
    logic [rmq_pkg::RW:0]     dsh;
    logic [rmq_pkg::QTW-1:0]  qv;
    logic [rmq_pkg::QW-1:0]   part;
    case (state_r)
      rmq_pkg::B_IDLE: begin
        br_r <= q_item.br;
        for (int i = 0; i < 4; i++) begin
          neg_r[i] <= u_in[i][rmq_pkg::UW-1];
          mag_r[i] <= u_in[i][rmq_pkg::UW-1] ? rmq_pkg::MAGW'(-u_in[i])
                                              : rmq_pkg::MAGW'(u_in[i]);
        end
      end
      rmq_pkg::B_SQR: begin
        for (int i = 0; i < 4; i++) begin
          sq_r[i] <= rmq_pkg::SQW'(mag_r[i]) * rmq_pkg::SQW'(mag_r[i]);
        end
      end
      rmq_pkg::B_SUM: begin
        s_r    <= rmq_pkg::SW'(sum_w);
        k_r    <= 5'd0;
        zero_r <= sum_zero;
      end
      rmq_pkg::B_NORM: begin
        // Shift by pairs of bits until the sum reaches the top two bits
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= 5'(rmq_pkg::RW - 1);
        if (s_r[61:44] == '0) begin
          s_r <= s_r << 16;
          k_r <= k_r + 5'd8;
        end else if (!norm_done) begin
          s_r <= s_r << 2;
          k_r <= k_r + 5'd1;
        end
      end
      rmq_pkg::B_SQRT: begin
        // One root digit a cycle
        s_r   <= s_r << 2;
        cnt_r <= cnt_r - 5'd1;
        if (sq_sh >= sq_trial) begin
          srem_r <= (rmq_pkg::RW+2)'(sq_sh - sq_trial);
          root_r <= {root_r[rmq_pkg::RW-2:0], 1'b1};
        end else begin
          srem_r <= (rmq_pkg::RW+2)'(sq_sh);
          root_r <= {root_r[rmq_pkg::RW-2:0], 1'b0};
        end
      end
      rmq_pkg::B_DINIT: begin
        cnt_r <= 5'(rmq_pkg::QTW - 1);
        for (int i = 0; i < 4; i++) begin
          magsh = 48'(mag_r[i]) << k_r;
          n_r[i] <= (rmq_pkg::NW'(magsh[rmq_pkg::RW-1:0]) << rmq_pkg::FRAC_BITS)
                  + rmq_pkg::NW'(root_r[rmq_pkg::RW-1:1]);
          drem_r[i] <= (rmq_pkg::RW+1)'(((rmq_pkg::NW'(magsh[rmq_pkg::RW-1:0])
                        << rmq_pkg::FRAC_BITS) + rmq_pkg::NW'(root_r[rmq_pkg::RW-1:1]))
                        >> rmq_pkg::QTW);
          q_r[i] <= '0;
        end
      end
      rmq_pkg::B_DIV: begin
        // One quotient bit a cycle in each of four dividers
        cnt_r <= cnt_r - 5'd1;
        for (int i = 0; i < 4; i++) begin
          dsh = {drem_r[i][rmq_pkg::RW-1:0], n_r[i][rmq_pkg::QTW-1]};
          n_r[i] <= n_r[i] << 1;
          if (dsh >= {1'b0, root_r}) begin
            drem_r[i] <= dsh - {1'b0, root_r};
            q_r[i]    <= {q_r[i][rmq_pkg::QTW-2:0], 1'b1};
          end else begin
            drem_r[i] <= dsh;
            q_r[i]    <= {q_r[i][rmq_pkg::QTW-2:0], 1'b0};
          end
        end
      end
      rmq_pkg::B_DONE: begin
        if (load_out) begin
          out_user_r <= br_r;
          for (int i = 0; i < 4; i++) begin
            qv   = (q_r[i] > rmq_pkg::QTW'(rmq_pkg::ONE)) ? rmq_pkg::QTW'(rmq_pkg::ONE)
                                                          : q_r[i];
            part = neg_r[i] ? rmq_pkg::QW'(-qv) : rmq_pkg::QW'(qv);
            if (zero_r) begin
              part = (i == 3) ? rmq_pkg::QW'(rmq_pkg::ONE) : '0;
            end
            out_data_r[i*rmq_pkg::QW +: rmq_pkg::QW] <= part;
          end
        end
      end
      default: begin
        zero_r <= zero_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Flow: an input transaction waits in the queue, then the back end squares and sums the
// parts, applies the normalizing shift, and runs the 31-step square-root unit and the
// 17-step dividers; an all-zero unscaled quaternion goes from the sum to the result.
// The back end handles one item at a time and holds a result while the output stalls;
// meanwhile a two-entry queue keeps accepting input transactions until it is full.
// Reset: synchronous, active low; clears the queue, the sequencer and out_tvalid.
module rotation_matrix_to_quaternion (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // quat_x quat_y quat_z quat_w, 16 bits each
  output logic [1:0]    out_tuser   // branch_taken
);

  logic           push, q_full, q_valid, pop;
  rmq_pkg::item_t push_item, q_item;

  rmq_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .push(push), .push_item(push_item), .q_full(q_full)
  );

  rmq_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_item(push_item), .full(q_full),
    .pop(pop), .valid(q_valid), .pop_item(q_item)
  );

  rmq_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

// ===== rtl/rmq_checker.sv =====
module rmq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Parts stay within one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[15:0]) <= 16384 && $signed(out_tdata[15:0]) >= -16384
      && $signed(out_tdata[31:16]) <= 16384 && $signed(out_tdata[31:16]) >= -16384
      && $signed(out_tdata[47:32]) <= 16384 && $signed(out_tdata[47:32]) >= -16384
      && $signed(out_tdata[63:48]) <= 16384 && $signed(out_tdata[63:48]) >= -16384)
    else $error("quaternion part out of range");

  // A unit quaternion is never all zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 64'd0)
    else $error("zero quaternion");

  // Drop valid after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
